[rtl/core/wfba_pkg.sv]
// Package for the worst-fit block allocator.
// Holds the sizing constants, transaction payload types, action codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package wfba_pkg;

  // Table sizing.
  localparam int unsigned NumBlocks = 16;
  localparam int unsigned SizeBits  = 16;
  localparam int unsigned IdxW      = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int unsigned CntW      = $clog2(NumBlocks + 1);

  // Fixed widths of the transaction fields.
  localparam int unsigned FieldSizeW = 16;
  localparam int unsigned FieldIdxW  = 4;

  // Action codes; code 3 is unused and fails.
  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]            action;
    logic [FieldSizeW-1:0] size;
    logic [FieldIdxW-1:0]  index;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic                  ok;
    logic [FieldIdxW-1:0]  block_index;
    logic [FieldSizeW-1:0] total_amt;
    logic [FieldSizeW-1:0] used_size;
    logic [FieldSizeW-1:0] free_amt;
  } out_item_t;

  // One partition table entry.
  typedef struct packed {
    logic [SizeBits-1:0] total;
    logic [SizeBits-1:0] used;
    logic [SizeBits-1:0] free;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;        // capture the accepted input item
    logic add_exec;     // append a partition, or fail when full
    logic read_issue;   // read the entry named by the item's index
    logic scan_start;   // read entry zero and clear the best candidate
    logic scan_step;    // compare the last entry read and read the next
    logic result_read;  // form the result from the entry just read
    logic commit;       // apply the allocation to the best candidate
    logic fail;         // form an all-zero failing result
    logic load_out;     // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       table_empty;
    logic       index_ok;
    logic       scan_last;
    logic       out_free;
  } status_t;

endpackage

[rtl/core/wfba_ctrl.sv]
// Controller of the worst-fit block allocator.
// Sequences one transaction at a time through dispatch, table read or scan and commit, and result.
// Depends on wfba_pkg for the command, status and action types.
`timescale 1ns / 1ps

module wfba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wfba_pkg::status_t status_i,
  output wfba_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_RDWAIT   = 6'b000100,
    S_SCAN     = 6'b001000,
    S_COMMIT   = 6'b010000,
    S_RESP     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (status_i.action == wfba_pkg::ACT_ADD) begin
          cmd_o.add_exec = 1'b1;
          state_d        = S_RESP;
        end else if (status_i.action == wfba_pkg::ACT_ALLOC) begin
          if (status_i.table_empty) begin
            cmd_o.fail = 1'b1;
            state_d    = S_RESP;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
        end else if (status_i.action == wfba_pkg::ACT_READ) begin
          if (status_i.index_ok) begin
            cmd_o.read_issue = 1'b1;
            state_d          = S_RDWAIT;
          end else begin
            cmd_o.fail = 1'b1;
            state_d    = S_RESP;
          end
        end else begin
          cmd_o.fail = 1'b1;
          state_d    = S_RESP;
        end
      end
      S_RDWAIT: begin
        cmd_o.result_read = 1'b1;
        state_d           = S_RESP;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/wfba_datapath.sv]
// Datapath of the worst-fit block allocator.
// Holds the partition table memory, the partition count, the scan compare
// and the output register. Depends on wfba_pkg.
`timescale 1ns / 1ps

module wfba_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wfba_pkg::in_item_t  in_item_i,
  input  wfba_pkg::cmd_t      cmd_i,
  output wfba_pkg::status_t   status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wfba_pkg::out_item_t out_item_o
);

  localparam int unsigned IdxW = wfba_pkg::IdxW;
  localparam int unsigned CntW = wfba_pkg::CntW;
  localparam int unsigned SzW  = wfba_pkg::SizeBits;
  localparam int unsigned FSzW = wfba_pkg::FieldSizeW;
  localparam int unsigned FIdW = wfba_pkg::FieldIdxW;

  // Partition table, one entry per partition.
  wfba_pkg::entry_t mem [wfba_pkg::NumBlocks];

  // Captured item.
  logic [1:0]      act_q;
  logic [SzW-1:0]  size_q;
  logic [FIdW-1:0] idx_q;

  // Control and scan state.
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_ptr_q, scan_ptr_d;
  logic            found_q, found_d;
  logic            out_valid_q, out_valid_d;

  // Payload registers.
  wfba_pkg::entry_t    rd_data_q;
  logic [IdxW-1:0]     rd_addr_q;
  wfba_pkg::entry_t    best_q, best_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  wfba_pkg::out_item_t res_q, res_d;
  wfba_pkg::out_item_t out_q;

  // Memory port signals.
  logic             mem_rd;
  logic [IdxW-1:0]  mem_raddr;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  wfba_pkg::entry_t mem_wdata;

  logic             table_full;
  logic             scan_more;
  logic             better;
  wfba_pkg::entry_t upd_entry;

  // Status towards the controller.
  assign table_full = (32'(count_q) >= 32'(wfba_pkg::NumBlocks));
  assign scan_more  = (scan_ptr_q < count_q);

  assign status_o.action      = act_q;
  assign status_o.table_empty = (count_q == '0);
  assign status_o.index_ok    = (32'(idx_q) < 32'(count_q));
  assign status_o.scan_last   = !scan_more;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  // Read port: scan pointer while scanning, item index for a read.
  always_comb begin
    mem_rd    = cmd_i.read_issue || cmd_i.scan_start || (cmd_i.scan_step && scan_more);
    mem_raddr = IdxW'(idx_q);
    if (cmd_i.scan_start) begin
      mem_raddr = '0;
    end else if (cmd_i.scan_step) begin
      mem_raddr = scan_ptr_q[IdxW-1:0];
    end
  end

  // Worst-fit compare of the entry just read against the best so far.
  assign better = (rd_data_q.free >= size_q) &&
                  (!found_q || (rd_data_q.free > best_q.free));

  // Allocation applied to the chosen partition.
  always_comb begin
    upd_entry       = best_q;
    upd_entry.used  = best_q.used + size_q;
    upd_entry.free  = best_q.free - size_q;
  end

  // Sequencing of count, scan state, result and memory write.
  always_comb begin
    count_d    = count_q;
    scan_ptr_d = scan_ptr_q;
    found_d    = found_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = count_q[IdxW-1:0];
    mem_wdata  = '0;

    if (cmd_i.add_exec) begin
      if (table_full) begin
        res_d = '0;
      end else begin
        mem_we            = 1'b1;
        mem_waddr         = count_q[IdxW-1:0];
        mem_wdata.total   = size_q;
        mem_wdata.used    = '0;
        mem_wdata.free    = size_q;
        count_d           = count_q + CntW'(1);
        res_d.ok          = 1'b1;
        res_d.block_index = FIdW'(count_q);
        res_d.total_amt   = FSzW'(size_q);
        res_d.used_size   = '0;
        res_d.free_amt    = FSzW'(size_q);
      end
    end

    if (cmd_i.scan_start) begin
      scan_ptr_d = CntW'(1);
      found_d    = 1'b0;
    end

    if (cmd_i.scan_step) begin
      if (better) begin
        found_d    = 1'b1;
        best_d     = rd_data_q;
        best_idx_d = rd_addr_q;
      end
      if (scan_more) begin
        scan_ptr_d = scan_ptr_q + CntW'(1);
      end
    end

    if (cmd_i.commit) begin
      if (found_q) begin
        mem_we            = 1'b1;
        mem_waddr         = best_idx_q;
        mem_wdata         = upd_entry;
        res_d.ok          = 1'b1;
        res_d.block_index = FIdW'(best_idx_q);
        res_d.total_amt   = FSzW'(upd_entry.total);
        res_d.used_size   = FSzW'(upd_entry.used);
        res_d.free_amt    = FSzW'(upd_entry.free);
      end else begin
        res_d = '0;
      end
    end

    if (cmd_i.result_read) begin
      res_d.ok          = 1'b1;
      res_d.block_index = FIdW'(rd_addr_q);
      res_d.total_amt   = FSzW'(rd_data_q.total);
      res_d.used_size   = FSzW'(rd_data_q.used);
      res_d.free_amt    = FSzW'(rd_data_q.free);
    end

    if (cmd_i.fail) begin
      res_d = '0;
    end
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_ptr_q  <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      scan_ptr_q  <= scan_ptr_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= in_item_i.action;
      size_q <= SzW'(in_item_i.size);
      idx_q  <= in_item_i.index;
    end
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  // Partition table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_rd) begin
      rd_data_q <= mem[mem_raddr];
      rd_addr_q <= mem_raddr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/core/worst_fit_block_allocator.sv]
// Worst-fit block allocator: one transaction in flight at a time.
// Add, a bad read, the unused action and an allocate on an empty table go
// from dispatch straight to the result; a good read waits on the registered
// table read, and any other allocate scans the table one entry per cycle;
// a stalled result holds off the input, and the next transaction is accepted
// once the result is registered in the output register.
// Reset is asynchronous, active low, and empties the table (count to zero).
`timescale 1ns / 1ps

module worst_fit_block_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wfba_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wfba_pkg::out_item_t out_item_o
);

  wfba_pkg::cmd_t    cmd;
  wfba_pkg::status_t status;

  // Controller.
  wfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  wfba_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[sim/wfba_table_checker.sv]
// Checker for the worst-fit block allocator: watches both transaction channels,
// keeps its own copy of the partition table and compares every result.
// Depends on wfba_pkg for the payload types, action codes and table sizing.
`timescale 1ns / 1ps

module wfba_table_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  wfba_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  wfba_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int ReportLimit = 10;
  localparam int unsigned SzW  = wfba_pkg::SizeBits;
  localparam int unsigned FSzW = wfba_pkg::FieldSizeW;
  localparam int unsigned FIdW = wfba_pkg::FieldIdxW;

  // Shadow copy of the partition table.
  logic [SzW-1:0] part_total [wfba_pkg::NumBlocks];
  logic [SzW-1:0] part_used  [wfba_pkg::NumBlocks];
  logic [SzW-1:0] part_free  [wfba_pkg::NumBlocks];
  int unsigned    part_count = 0;

  // Results still owed by the block, oldest first.
  wfba_pkg::out_item_t pending_replies [$];
  int                  mismatches  = 0;
  int                  reply_depth = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = reply_depth;

  // Figures of one table entry as the block reports them.
  function automatic wfba_pkg::out_item_t entry_status(int unsigned slot);
    wfba_pkg::out_item_t r;
    r.ok          = 1'b1;
    r.block_index = FIdW'(slot);
    r.total_amt   = FSzW'(part_total[slot]);
    r.used_size   = FSzW'(part_used[slot]);
    r.free_amt    = FSzW'(part_free[slot]);
    return r;
  endfunction

  // Apply one request to the shadow table and return the result it should give.
  function automatic wfba_pkg::out_item_t update_table(wfba_pkg::in_item_t req);
    logic [SzW-1:0]      amount;
    int unsigned         best;
    bit                  found;
    wfba_pkg::out_item_t r;
    amount = req.size[SzW-1:0];
    best   = 0;
    found  = 1'b0;
    r      = '0;
    unique case (wfba_pkg::action_e'(req.action))
      wfba_pkg::ACT_ADD: begin
        // A full table refuses the new partition and stays as it is.
        if (part_count < wfba_pkg::NumBlocks) begin
          part_total[part_count] = amount;
          part_used[part_count]  = '0;
          part_free[part_count]  = amount;
          r = entry_status(part_count);
          part_count++;
        end
      end
      wfba_pkg::ACT_ALLOC: begin
        // Largest free space that still fits; strict compare keeps the lowest
        // index on a tie.
        for (int unsigned i = 0; i < part_count; i++) begin
          if (part_free[i] >= amount && (!found || part_free[i] > part_free[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (found) begin
          part_used[best] = part_used[best] + amount;
          part_free[best] = part_free[best] - amount;
          r = entry_status(best);
        end
      end
      wfba_pkg::ACT_READ: begin
        if (32'(req.index) < part_count) begin
          r = entry_status(32'(req.index));
        end
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string what, wfba_pkg::out_item_t want);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display({"%0t: %s: expected ok=%0d blk=%0d total=%0d used=%0d free=%0d, ",
                "got ok=%0d blk=%0d total=%0d used=%0d free=%0d"},
               $time, what, want.ok, want.block_index, want.total_amt, want.used_size,
               want.free_amt, out_item_i.ok, out_item_i.block_index, out_item_i.total_amt,
               out_item_i.used_size, out_item_i.free_amt);
    end
  endtask

  // Results are compared before new requests are queued, so a result and an
  // acceptance on the same edge never pair up with each other.
  always @(posedge clk_i) begin
    wfba_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (pending_replies.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0);
        end else begin
          want = pending_replies.pop_front();
          if (want.ok !== out_item_i.ok || want.block_index !== out_item_i.block_index ||
              want.total_amt !== out_item_i.total_amt ||
              want.used_size !== out_item_i.used_size ||
              want.free_amt !== out_item_i.free_amt) begin
            note_mismatch("result mismatch", want);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_replies.push_back(update_table(in_item_i));
      end
    end
    reply_depth <= pending_replies.size();
  end

endmodule

[sim/worst_fit_block_allocator_tb.sv]
// Testbench top for the worst-fit block allocator: drives requests, paces the
// result channel and gives the verdict. Depends on wfba_pkg, the block itself
// and wfba_table_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module worst_fit_block_allocator_tb;

  localparam int StallLimit = 2000;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 350;
  localparam int Phases     = 4;
  localparam int FillAdds   = 11;
  localparam int DrainWait  = 40;

  // The package enum leaves the fourth action code unnamed; the block must fail it.
  localparam logic [1:0] ActUnused = 2'd3;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  wfba_pkg::in_item_t  in_item       = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  wfba_pkg::out_item_t out_item;
  int                  fail_count;
  int                  pending;
  int                  src_idle_pct  = 0;
  int                  sink_idle_pct = 0;
  logic                long_hold_req = 1'b0;
  int                  idle_cycles   = 0;

  always #6 clk_i = ~clk_i;

  worst_fit_block_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  wfba_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Idle stretch length: mostly a few cycles, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(13, 40);
  endfunction

  // Offer one request and wait for its transaction. Valid is only lowered when
  // an idle gap comes first, so back-to-back requests keep it high.
  task automatic issue(logic [1:0] act, logic [15:0] amount, logic [3:0] slot);
    wfba_pkg::in_item_t req;
    int                 gap;
    req.action = act;
    req.size   = amount;
    req.index  = slot;
    gap = 0;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      gap = gap_length();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly allocations of small sizes, so the table keeps serving for a long run.
  task automatic random_request();
    int          r;
    int          pick;
    logic [15:0] amount;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        amount = '0;
      end else if (pick < 75) begin
        amount = 16'($urandom_range(1, 255));
      end else if (pick < 90) begin
        amount = 16'($urandom_range(256, 4095));
      end else begin
        amount = 16'($urandom);
      end
      issue(wfba_pkg::ACT_ALLOC, amount, 4'($urandom));
    end else if (r < 85) begin
      issue(wfba_pkg::ACT_READ, 16'($urandom), 4'($urandom));
    end else if (r < 95) begin
      issue(wfba_pkg::ACT_ADD, 16'($urandom), 4'($urandom));
    end else begin
      issue(ActUnused, 16'($urandom), 4'($urandom));
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        out_ready <= 1'b0;
        repeat (gap_length()) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    src_idle_pct  = 20;
    sink_idle_pct = 20;

    // Empty table: bad read, allocations that cannot fit, unused action.
    issue(wfba_pkg::ACT_READ, 16'h0000, 4'h0);
    issue(wfba_pkg::ACT_ALLOC, 16'd5, 4'h0);
    issue(wfba_pkg::ACT_ALLOC, 16'h0000, 4'hF);
    issue(ActUnused, 16'hFFFF, 4'hF);

    // Partitions at the extremes, with two equal sizes for the tie.
    issue(wfba_pkg::ACT_ADD, 16'hFFFF, 4'h0);
    issue(wfba_pkg::ACT_ADD, 16'h0000, 4'hF);
    issue(wfba_pkg::ACT_ADD, 16'd100, 4'h0);
    issue(wfba_pkg::ACT_ADD, 16'd100, 4'h0);
    issue(wfba_pkg::ACT_ADD, 16'h8000, 4'h0);

    // Zero request, exact fit, shrink the largest, tie, and no fit.
    issue(wfba_pkg::ACT_ALLOC, 16'h0000, 4'h0);
    issue(wfba_pkg::ACT_ALLOC, 16'hFFFF, 4'h0);
    issue(wfba_pkg::ACT_ALLOC, 16'h7FA0, 4'h0);
    issue(wfba_pkg::ACT_ALLOC, 16'd100, 4'h0);
    issue(wfba_pkg::ACT_ALLOC, 16'hFFFF, 4'h0);

    // Reads past the end and of live entries.
    issue(wfba_pkg::ACT_READ, 16'h0000, 4'hF);
    issue(wfba_pkg::ACT_READ, 16'hFFFF, 4'h4);
    issue(wfba_pkg::ACT_READ, 16'h0000, 4'h1);

    // Fill the table, then one add too many.
    repeat (FillAdds) issue(wfba_pkg::ACT_ADD, 16'($urandom), 4'($urandom));
    issue(wfba_pkg::ACT_ADD, 16'h1234, 4'h0);
    drain_replies();

    // Random phases with different pacing, draining in between.
    for (int p = 0; p < Phases; p++) begin
      unique case (p)
        0: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
        1: begin
          src_idle_pct  = 30;
          sink_idle_pct = 30;
          long_hold_req <= 1'b1;
        end
        2: begin
          src_idle_pct  = 60;
          sink_idle_pct = 10;
        end
        default: begin
          src_idle_pct  = 10;
          sink_idle_pct = 60;
        end
      endcase
      repeat (PhaseItems) random_request();
      drain_replies();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
